FILE: rtl/bfft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfft_pkg
// Shared widths, codes, reset values and the configuration record of the
// bounded FIFO with fill throttle.
// ----------------------------------------------------------------------------
package bfft_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 64;

    localparam int CAP_W     = 11;
    localparam int PCT_W     = 7;
    localparam int OCC_W     = 11;
    localparam int LVL_W     = 3;
    localparam int WORD_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 11;
    localparam int M_DATA_W  = 88;
    localparam int PROD_W    = CAP_W + PCT_W;
    localparam int PCT_SCALE = 100;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_FOUR  = 3'd4;

    // reset values
    localparam logic [CAP_W-1:0] CAPACITY_RST    = 11'd0;
    localparam logic [PCT_W-1:0] LEVEL_ONE_RST   = 7'd20;
    localparam logic [PCT_W-1:0] LEVEL_TWO_RST   = 7'd40;
    localparam logic [PCT_W-1:0] LEVEL_THREE_RST = 7'd60;
    localparam logic [PCT_W-1:0] LEVEL_FOUR_RST  = 7'd80;

    // operation codes
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    // throttle levels
    localparam logic [LVL_W-1:0] LVL_NONE  = 3'd0;
    localparam logic [LVL_W-1:0] LVL_ONE   = 3'd1;
    localparam logic [LVL_W-1:0] LVL_TWO   = 3'd2;
    localparam logic [LVL_W-1:0] LVL_THREE = 3'd3;
    localparam logic [LVL_W-1:0] LVL_FOUR  = 3'd4;

    typedef struct packed {
        logic [CAP_W-1:0] capacity;
        logic [PCT_W-1:0] level_one_pct;
        logic [PCT_W-1:0] level_two_pct;
        logic [PCT_W-1:0] level_three_pct;
        logic [PCT_W-1:0] level_four_pct;
    } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/bfft_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfft_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bfft_store #(
    parameter int DEPTH      = bfft_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bfft_pkg::DATA_WIDTH_DEF,
    localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   aclk,
    input  wire logic                   wr_en,
    input  wire logic [PTR_W-1:0]       wr_addr,
    input  wire logic [DATA_WIDTH-1:0]  wr_data,
    input  wire logic                   rd_en,
    input  wire logic [PTR_W-1:0]       rd_addr,
    output logic      [DATA_WIDTH-1:0]  rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/bfft_throttle.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfft_throttle
// Throttle level from fill: pct < t is tested as count*100 < t*capacity.
// ----------------------------------------------------------------------------
module bfft_throttle #(
    parameter int DEPTH  = bfft_pkg::DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                           aclk,
    input  wire bfft_pkg::cfg_t                 cfg,
    input  wire logic [CNT_W-1:0]               count,
    output logic      [bfft_pkg::LVL_W-1:0]     level
);

    localparam int SCL_W = CNT_W + 7;
    localparam int CW    = (SCL_W > bfft_pkg::PROD_W) ? SCL_W : bfft_pkg::PROD_W;

    localparam int PW = bfft_pkg::PROD_W;

    // threshold*capacity, refreshed every cycle from the config registers
    logic [PW-1:0] prod1_reg;
    logic [PW-1:0] prod2_reg;
    logic [PW-1:0] prod3_reg;
    logic [PW-1:0] prod4_reg;
    logic [CW-1:0] scaled;
    logic          lt1, lt2, lt3, lt4;

    always_ff @(posedge aclk) begin
        prod1_reg <= PW'(cfg.level_one_pct)   * PW'(cfg.capacity);
        prod2_reg <= PW'(cfg.level_two_pct)   * PW'(cfg.capacity);
        prod3_reg <= PW'(cfg.level_three_pct) * PW'(cfg.capacity);
        prod4_reg <= PW'(cfg.level_four_pct)  * PW'(cfg.capacity);
    end

    always_comb begin
        scaled = CW'(count) * CW'(bfft_pkg::PCT_SCALE);
        lt1    = scaled < CW'(prod1_reg);
        lt2    = scaled < CW'(prod2_reg);
        lt3    = scaled < CW'(prod3_reg);
        lt4    = scaled < CW'(prod4_reg);
        if (lt1) begin
            level = bfft_pkg::LVL_NONE;
        end else if (lt2) begin
            level = bfft_pkg::LVL_ONE;
        end else if (lt3) begin
            level = bfft_pkg::LVL_TWO;
        end else if (lt4) begin
            level = bfft_pkg::LVL_THREE;
        end else begin
            level = bfft_pkg::LVL_FOUR;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/bounded_fifo_with_fill_throttle.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_fifo_with_fill_throttle
// Message FIFO with a programmable capacity and a four-threshold fill throttle.
// ----------------------------------------------------------------------------
// Each input item is an enqueue (tuser 0) or a dequeue (tuser 1) and gives
// exactly one result item. The accept cycle decides the operation and
// accesses the entry memory; the result state then takes the registered read
// data of the single memory read port and the throttle compare into the
// output register once the result side is ready. No new item is taken in the
// result state, and a stalled result side holds the block there.
// A finished result may wait in the output register while the next item is
// taken. The entry memory needs no clearing after reset, since only held
// entries are ever read. Capacity 0 means the physical depth is the only
// bound; throttle levels are given only for stored enqueues with capacity set.
// ----------------------------------------------------------------------------
module bounded_fifo_with_fill_throttle #(
    parameter int DEPTH      = bfft_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bfft_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [bfft_pkg::WORD_W-1:0]        s_tdata,    // [63:0] payload
    input  wire logic                               s_tuser,    // [0] mode
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [0] accepted, [11:1] occupancy, [12] data_valid, [76:13] data_out,
    // [77] throttle_valid, [80:78] throttle_level, [87:81] zero
    output logic      [bfft_pkg::M_DATA_W-1:0]      m_tdata,
    input  wire logic                               cfg_we,
    input  wire logic [bfft_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bfft_pkg::CFG_DAT_W-1:0]     cfg_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > bfft_pkg::CAP_W) ? CNT_W : bfft_pkg::CAP_W;

    localparam logic [0:0] ST_IDLE   = 1'b0;
    localparam logic [0:0] ST_RESULT = 1'b1;

    logic [0:0]            state_reg, state_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  mode_reg;
    logic                  done_reg;
    bfft_pkg::cfg_t        cfg_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [bfft_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic                  take;
    logic                  is_enq;
    logic                  room;
    logic                  cap_set;
    logic                  enq_go;
    logic                  deq_go;
    logic                  load_out;
    logic [CMP_W-1:0]      cnt_ext, cap_ext, dep_ext;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [bfft_pkg::LVL_W-1:0] level;

    logic                          r_accepted, r_dvalid, r_tvalid;
    logic [bfft_pkg::WORD_W-1:0]   r_data;
    logic [bfft_pkg::LVL_W-1:0]    r_level;
    logic [bfft_pkg::M_DATA_W-1:0] r_word;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---- configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.capacity        <= bfft_pkg::CAPACITY_RST;
            cfg_reg.level_one_pct   <= bfft_pkg::LEVEL_ONE_RST;
            cfg_reg.level_two_pct   <= bfft_pkg::LEVEL_TWO_RST;
            cfg_reg.level_three_pct <= bfft_pkg::LEVEL_THREE_RST;
            cfg_reg.level_four_pct  <= bfft_pkg::LEVEL_FOUR_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                bfft_pkg::CFG_CAPACITY: begin
                    cfg_reg.capacity <= cfg_data;
                end
                bfft_pkg::CFG_LEVEL_ONE: begin
                    cfg_reg.level_one_pct <= cfg_data[bfft_pkg::PCT_W-1:0];
                end
                bfft_pkg::CFG_LEVEL_TWO: begin
                    cfg_reg.level_two_pct <= cfg_data[bfft_pkg::PCT_W-1:0];
                end
                bfft_pkg::CFG_LEVEL_THREE: begin
                    cfg_reg.level_three_pct <= cfg_data[bfft_pkg::PCT_W-1:0];
                end
                bfft_pkg::CFG_LEVEL_FOUR: begin
                    cfg_reg.level_four_pct <= cfg_data[bfft_pkg::PCT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---- operation decision in the accept cycle
    always_comb begin
        take    = s_tvalid && s_tready;
        is_enq  = (s_tuser == bfft_pkg::MODE_ENQ);
        cap_set = (cfg_reg.capacity != '0);
        cnt_ext = CMP_W'(count_reg);
        cap_ext = CMP_W'(cfg_reg.capacity);
        dep_ext = CMP_W'(DEPTH);
        // capacity above the depth leaves the depth as bound
        if (cap_set && (cap_ext < dep_ext)) begin
            room = cnt_ext < cap_ext;
        end else begin
            room = cnt_ext < dep_ext;
        end
        enq_go = take && is_enq && room;
        deq_go = take && !is_enq && (count_reg != '0);

        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (enq_go) begin
            tail_next  = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        if (deq_go) begin
            head_next  = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    bfft_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (enq_go),
        .wr_addr (tail_reg),
        .wr_data (s_tdata[DATA_WIDTH-1:0]),
        .rd_en   (deq_go),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    bfft_throttle #(
        .DEPTH (DEPTH)
    ) u_throttle (
        .aclk  (aclk),
        .cfg   (cfg_reg),
        .count (count_reg),
        .level (level)
    );

    // ---- result forming; count_reg already holds the post-op occupancy
    always_comb begin
        load_out   = (state_reg == ST_RESULT) && (!m_tvalid_reg || m_tready);
        r_accepted = (mode_reg == bfft_pkg::MODE_ENQ) && done_reg;
        r_dvalid   = (mode_reg == bfft_pkg::MODE_DEQ) && done_reg;
        r_data     = r_dvalid ? bfft_pkg::WORD_W'(rd_data) : '0;
        r_tvalid   = r_accepted && (cfg_reg.capacity != '0);
        r_level    = r_tvalid ? level : bfft_pkg::LVL_NONE;
        r_word     = {7'b0, r_level, r_tvalid, r_data, r_dvalid,
                      bfft_pkg::OCC_W'(count_reg), r_accepted};

        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_tvalid_next = m_tvalid_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            mode_reg <= s_tuser;
            done_reg <= enq_go || deq_go;
        end
        if (load_out) begin
            m_tdata_reg <= r_word;
        end
    end

    // ---- checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= CMP_W'(DEPTH))
        else $error("occupancy beyond physical depth");

    a_take_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_RESULT))
        else $error("accepted item did not enter result cycle");

    a_load_from_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result loaded outside result cycle");

    a_single_op: assert property (@(posedge aclk) disable iff (!aresetn)
        !(enq_go && deq_go))
        else $error("enqueue and dequeue in the same cycle");

    a_throttle_needs_store: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (!m_tdata_reg[77] || m_tdata_reg[0]))
        else $error("throttle level without stored item");

endmodule
`default_nettype wire
